### rtl/core/dds_pkg.sv
// Shared types, constants and tables for the delta decimal stream formatter.
`default_nettype none
package dds_pkg;

  localparam int VALUE_W        = 32;
  localparam int COUNT_W        = 32;
  localparam int SUM_W          = 64;
  localparam int GAP_BITS       = 16;
  localparam int DEC_DIGITS     = 10;
  localparam int DIGIT_IDX_W    = $clog2(DEC_DIGITS);
  localparam int WIDE_W         = 36;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [7:0] ASCII_ZERO = 8'h30;
  localparam logic [7:0] ASCII_NL   = 8'h0A;

  localparam logic [1:0] MODE_DEC_VALUE = 2'd0;
  localparam logic [1:0] MODE_BIN_VALUE = 2'd1;
  localparam logic [1:0] MODE_DEC_GAP   = 2'd2;
  localparam logic [1:0] MODE_BIN_GAP   = 2'd3;

  localparam logic REG_FORMAT_MODE = 1'b0;
  localparam logic REG_START_VALUE = 1'b1;

  localparam logic [WIDE_W-1:0] POW10 [DEC_DIGITS] = '{
    36'd1, 36'd10, 36'd100, 36'd1000, 36'd10000, 36'd100000,
    36'd1000000, 36'd10000000, 36'd100000000, 36'd1000000000
  };

  typedef enum logic [1:0] {
    KIND_ERR,
    KIND_DEC,
    KIND_BIN4,
    KIND_BIN2
  } kind_t;

  typedef struct packed {
    kind_t                  kind;
    logic [VALUE_W-1:0]     data;
    logic [DIGIT_IDX_W-1:0] top;
    logic [COUNT_W-1:0]     count;
    logic [SUM_W-1:0]       sum;
  } cmd_t;

endpackage
`default_nettype wire

### rtl/core/dds_front.sv
// Front end: takes items, checks the gap, updates running state, builds commands.
`default_nettype none
module dds_front import dds_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic               cfg_index,
  input  wire logic [31:0]        cfg_data,
  input  wire logic               in_valid,
  input  wire logic [VALUE_W-1:0] value_in,
  input  wire logic               q_ready,
  output logic                    in_stall,
  output logic                    q_push,
  output cmd_t                    q_cmd
);

  logic [1:0]         format_mode;
  logic [VALUE_W-1:0] previous_value;
  logic [COUNT_W-1:0] accepted_count;
  logic [SUM_W-1:0]   running_sum;

  logic [VALUE_W-1:0] gap;
  logic               gap_err;
  logic [VALUE_W-1:0] opnd;
  logic [COUNT_W-1:0] count_next;
  logic [SUM_W-1:0]   sum_next;

  assign in_stall   = !q_ready;
  assign q_push     = in_valid && q_ready;
  assign gap        = value_in - previous_value;
  assign gap_err    = |gap[VALUE_W-1:GAP_BITS];
  assign count_next = accepted_count + 1'b1;
  assign sum_next   = running_sum + {{(SUM_W-VALUE_W){1'b0}}, value_in};

  always_comb begin
    logic [DIGIT_IDX_W-1:0] top;
    opnd = format_mode[1] ? {{(VALUE_W-GAP_BITS){1'b0}}, gap[GAP_BITS-1:0]} : value_in;
    top  = '0;
    for (int k = 1; k < DEC_DIGITS; k++) begin
      if ({{(WIDE_W-VALUE_W){1'b0}}, opnd} >= POW10[k]) top = DIGIT_IDX_W'(k);
    end
    q_cmd.data = opnd;
    q_cmd.top  = top;
    if (gap_err) begin
      q_cmd.kind  = KIND_ERR;
      q_cmd.count = accepted_count;
      q_cmd.sum   = running_sum;
    end else begin
      unique case (format_mode)
        MODE_DEC_VALUE: q_cmd.kind = KIND_DEC;
        MODE_BIN_VALUE: q_cmd.kind = KIND_BIN4;
        MODE_DEC_GAP:   q_cmd.kind = KIND_DEC;
        MODE_BIN_GAP:   q_cmd.kind = KIND_BIN2;
        default:        q_cmd.kind = KIND_DEC;
      endcase
      q_cmd.count = count_next;
      q_cmd.sum   = sum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      format_mode    <= MODE_DEC_VALUE;
      previous_value <= '0;
      accepted_count <= '0;
      running_sum    <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_FORMAT_MODE: format_mode    <= cfg_data[1:0];
          REG_START_VALUE: previous_value <= cfg_data[VALUE_W-1:0];
          default: ;
        endcase
      end else if (q_push && !gap_err) begin
        previous_value <= value_in;
        accepted_count <= count_next;
        running_sum    <= sum_next;
      end
    end
  end

endmodule
`default_nettype wire

### rtl/core/dds_queue.sv
// Short command queue between the front and back ends.
`default_nettype none
module dds_queue import dds_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  output logic      ready,
  input  wire logic pop,
  output cmd_t      head,
  output logic      head_valid
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;

  assign ready      = fill != CNT_W'(DEPTH);
  assign head_valid = fill != '0;
  assign head       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (push && !pop)      fill <= fill + 1'b1;
      else if (pop && !push) fill <= fill - 1'b1;
    end
  end

endmodule
`default_nettype wire

### rtl/core/dds_back.sv
// Back end: expands one command into its byte run, one byte per cycle while the output is not stalled.
`default_nettype none
module dds_back import dds_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire cmd_t        head,
  input  wire logic        head_valid,
  output logic             pop,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_byte,
  output logic             last_byte,
  output logic             gap_error,
  output logic [COUNT_W-1:0] item_count,
  output logic [SUM_W-1:0]   value_sum
);

  logic                   busy;
  kind_t                  cur_kind;
  logic [VALUE_W-1:0]     cur_data;
  logic [DIGIT_IDX_W-1:0] cur_k;
  logic                   cur_nl;
  logic [1:0]             cur_pos;
  logic [COUNT_W-1:0]     cur_count;
  logic [SUM_W-1:0]       cur_sum;

  logic                   adv;
  logic [7:0]             byte_c;
  logic                   last_c;
  logic                   err_c;
  logic [VALUE_W-1:0]     rem_next;
  logic [3:0]             dig;

  assign adv = busy && (!out_valid || !out_stall);
  assign pop = head_valid && (!busy || (adv && last_c));

  // most significant digit first against multiples of the current power of ten
  always_comb begin
    logic [WIDE_W-1:0] p;
    logic [WIDE_W-1:0] thr [DEC_DIGITS];
    p   = POW10[cur_k];
    dig = '0;
    for (int d = 0; d < DEC_DIGITS; d++) begin
      thr[d] = p * WIDE_W'(d);
      if ({{(WIDE_W-VALUE_W){1'b0}}, cur_data} >= thr[d]) dig = 4'(d);
    end
    rem_next = cur_data - thr[dig][VALUE_W-1:0];
  end

  always_comb begin
    logic [1:0] idx;
    idx    = 2'd3 - cur_pos;
    byte_c = '0;
    last_c = 1'b0;
    err_c  = 1'b0;
    unique case (cur_kind)
      KIND_ERR: begin
        last_c = 1'b1;
        err_c  = 1'b1;
      end
      KIND_BIN4: begin
        byte_c = cur_data[{idx, 3'b000} +: 8];
        last_c = cur_pos == 2'd3;
      end
      KIND_BIN2: begin
        byte_c = cur_pos[0] ? cur_data[7:0] : cur_data[15:8];
        last_c = cur_pos[0];
      end
      KIND_DEC: begin
        if (cur_nl) begin
          byte_c = ASCII_NL;
          last_c = 1'b1;
        end else begin
          byte_c = ASCII_ZERO + {4'b0000, dig};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pop) busy <= 1'b1;
      else if (adv && last_c) busy <= 1'b0;
      if (adv) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_byte   <= byte_c;
      last_byte  <= last_c;
      gap_error  <= err_c;
      item_count <= cur_count;
      value_sum  <= cur_sum;
    end
    if (pop) begin
      cur_kind  <= head.kind;
      cur_data  <= head.data;
      cur_k     <= head.top;
      cur_nl    <= 1'b0;
      cur_pos   <= '0;
      cur_count <= head.count;
      cur_sum   <= head.sum;
    end else if (adv && !last_c) begin
      cur_pos <= cur_pos + 1'b1;
      if (cur_kind == KIND_DEC) begin
        cur_data <= rem_next;
        if (cur_k == '0) cur_nl <= 1'b1;
        else cur_k <= cur_k - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

### rtl/core/delta_decimal_stream_formatter.sv
// Top level of the delta decimal stream formatter.
//
// Input channel: in_valid / in_stall / value_in, one 32-bit value per transfer.
// Output channel: out_valid / out_stall, one byte per transfer with last_byte,
// gap_error, item_count and value_sum.
// Configuration: cfg_we / cfg_index / cfg_data; index 0 is the format mode,
// index 1 the start value, which also loads the previous value.
// The front end checks the gap and queues a command for each input transfer; it updates
// count, sum and previous value only when there is no gap error and no configuration
// write. The back end expands each command into bytes, one byte per cycle from the
// output register while the output is not stalled. A value passes through a queue entry
// and the back-end command register before its first byte goes to the output register.
// Each item yields 1 byte for a gap error, 2 or 4 in binary modes, digits plus one (2 to
// 11) in decimal modes; the next command is taken as the last byte of one is emitted.
// in_stall rises when the command queue is full.
// Reset clears mode, previous value, count and sum, and empties the queue.
// A stalled receiver holds the output byte; the queue then fills and
// backpressure reaches the input.
`default_nettype none
module delta_decimal_stream_formatter import dds_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic               cfg_index,
  input  wire logic [31:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [VALUE_W-1:0] value_in,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [7:0]              out_byte,
  output logic                    last_byte,
  output logic                    gap_error,
  output logic [COUNT_W-1:0]      item_count,
  output logic [SUM_W-1:0]        value_sum
);

  logic q_ready;
  logic q_push;
  cmd_t q_cmd;
  logic q_pop;
  cmd_t q_head;
  logic q_head_valid;

  dds_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .value_in (value_in),
    .q_ready  (q_ready),
    .in_stall (in_stall),
    .q_push   (q_push),
    .q_cmd    (q_cmd)
  );

  dds_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_cmd  (q_cmd),
    .ready     (q_ready),
    .pop       (q_pop),
    .head      (q_head),
    .head_valid(q_head_valid)
  );

  dds_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (q_head),
    .head_valid(q_head_valid),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .last_byte (last_byte),
    .gap_error (gap_error),
    .item_count(item_count),
    .value_sum (value_sum)
  );

endmodule
`default_nettype wire

### test/delta_decimal_stream_formatter_tb.sv
// Self-checking testbench for delta_decimal_stream_formatter: byte-stream prediction and compare.
`timescale 1ns / 1ps
module delta_decimal_stream_formatter_tb;
  import dds_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PRINT_LIMIT = 40;

  typedef struct {
    logic [7:0]         data;
    logic               last;
    logic               err;
    logic [COUNT_W-1:0] count;
    logic [SUM_W-1:0]   sum;
  } fmt_byte_t;

  class byte_run_tracker;
    logic [1:0]         mode;
    logic [VALUE_W-1:0] last_value;
    logic [COUNT_W-1:0] count;
    logic [SUM_W-1:0]   sum;
    fmt_byte_t          pending[$];
    int                 mismatches;
    int                 items;
    int                 rejects;
    int                 bytes_checked;

    function new();
      mode = MODE_DEC_VALUE;
      last_value = '0;
      count = '0;
      sum = '0;
      mismatches = 0;
      items = 0;
      rejects = 0;
      bytes_checked = 0;
    endfunction

    function void set_mode(logic [31:0] d);
      mode = d[1:0];
    endfunction

    function void set_start(logic [31:0] d);
      last_value = d;
    endfunction

    function void push_byte(logic [7:0] d, logic l, logic e);
      fmt_byte_t b;
      b.data = d;
      b.last = l;
      b.err = e;
      b.count = count;
      b.sum = sum;
      pending.push_back(b);
    endfunction

    function void note_value(logic [VALUE_W-1:0] v);
      logic [VALUE_W-1:0] gap;
      logic [VALUE_W-1:0] x;
      logic [7:0]         run[$];
      gap = v - last_value;
      items++;
      if (gap[VALUE_W-1:GAP_BITS] != '0) begin
        rejects++;
        push_byte(8'h00, 1'b1, 1'b1);
        return;
      end
      case (mode)
        MODE_DEC_VALUE, MODE_DEC_GAP: begin
          x = (mode == MODE_DEC_VALUE) ? v : gap;
          do begin
            run.push_front(ASCII_ZERO + 8'(x % 10));
            x = x / 10;
          end while (x != 0);
          run.push_back(ASCII_NL);
        end
        MODE_BIN_VALUE: begin
          run.push_back(v[31:24]);
          run.push_back(v[23:16]);
          run.push_back(v[15:8]);
          run.push_back(v[7:0]);
        end
        default: begin
          run.push_back(gap[15:8]);
          run.push_back(gap[7:0]);
        end
      endcase
      last_value = v;
      count = count + 1;
      sum = sum + SUM_W'(v);
      foreach (run[k]) push_byte(run[k], k == run.size() - 1, 1'b0);
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      if (mismatches <= PRINT_LIMIT) $display("ERROR at %0t: %s", $time, msg);
    endtask

    task check_byte(logic [7:0] d, logic l, logic e, logic [COUNT_W-1:0] c,
                    logic [SUM_W-1:0] s);
      fmt_byte_t x;
      bytes_checked++;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("unexpected output transfer, byte %h", d));
        return;
      end
      x = pending.pop_front();
      if (d !== x.data) report_mismatch($sformatf("out_byte %h, want %h", d, x.data));
      if (l !== x.last) report_mismatch($sformatf("last_byte %b, want %b", l, x.last));
      if (e !== x.err) report_mismatch($sformatf("gap_error %b, want %b", e, x.err));
      if (c !== x.count) report_mismatch($sformatf("item_count %0d, want %0d", c, x.count));
      if (s !== x.sum) report_mismatch($sformatf("value_sum %0d, want %0d", s, x.sum));
    endtask
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic               cfg_index = REG_FORMAT_MODE;
  logic [31:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [VALUE_W-1:0] value_in = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [7:0]         out_byte;
  logic               last_byte;
  logic               gap_error;
  logic [COUNT_W-1:0] item_count;
  logic [SUM_W-1:0]   value_sum;

  byte_run_tracker tracker;
  bit              quiet_send = 1'b0;
  bit              quiet_recv = 1'b0;
  int              cycles = 0;

  delta_decimal_stream_formatter dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .value_in   (value_in),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .last_byte  (last_byte),
    .gap_error  (gap_error),
    .item_count (item_count),
    .value_sum  (value_sum)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL delta_decimal_stream_formatter");
      $finish;
    end
  end

  task automatic write_reg(input logic idx, input logic [31:0] d);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    if (idx == REG_FORMAT_MODE) tracker.set_mode(d);
    else tracker.set_start(d);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_value(input logic [VALUE_W-1:0] v);
    int idle;
    idle = quiet_send ? 0 : $urandom_range(0, 4);
    if (idle > 0) begin
      in_valid <= 1'b0;
      value_in <= $urandom();
      repeat (idle) @(posedge clk);
    end
    in_valid <= 1'b1;
    value_in <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.note_value(v);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (tracker.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic random_phase(input int p, input int n);
    logic [VALUE_W-1:0] gap;
    logic [31:0]        start;
    logic [1:0]         m;
    m = (p < 4) ? 2'(p) : 2'($urandom_range(0, 3));
    start = (p == 0) ? 32'h0 : (p == 1) ? 32'hFFFF_FFFF : $urandom();
    write_reg(REG_FORMAT_MODE, ($urandom() & ~32'h3) | 32'(m));
    write_reg(REG_START_VALUE, start);
    quiet_send = ($urandom_range(0, 3) == 0);
    quiet_recv = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < n; i++) begin
      if (i == n / 2) begin
        drain_results();
        quiet_send = ($urandom_range(0, 3) == 0);
        quiet_recv = ($urandom_range(0, 3) == 0);
      end
      case ($urandom_range(0, 9))
        0: gap = $urandom_range(32'h0001_0000, 32'hFFFF_FFFF);
        1: gap = 32'h0000_FFFF;
        2: gap = 32'h0;
        3, 4: gap = $urandom_range(0, 99);
        default: gap = $urandom_range(0, 32'h0000_FFFF);
      endcase
      send_value(tracker.last_value + gap);
    end
    drain_results();
  endtask

  initial begin : sink
    int hold;
    wait (rst == 1'b0);
    @(posedge clk);
    forever begin
      hold = quiet_recv ? 0 : $urandom_range(0, 4);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      tracker.check_byte(out_byte, last_byte, gap_error, item_count, value_sum);
    end
  end

  initial begin
    tracker = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset defaults: decimal value, previous value zero
    send_value(32'd0);
    send_value(32'd9);
    send_value(32'd10);
    send_value(32'd65546);
    send_value(32'd65545);
    drain_results();

    // widest decimal run, gap wrapping through zero, huge gap
    write_reg(REG_START_VALUE, 32'hFFFF_0000);
    send_value(32'hFFFF_FFFF);
    send_value(32'h0000_0000);
    send_value(32'hFFFF_FFFF);
    drain_results();

    // binary value; upper mode bits must be masked
    write_reg(REG_FORMAT_MODE, 32'hFFFF_FFFD);
    write_reg(REG_START_VALUE, 32'hA5A5_5A5A);
    send_value(32'hA5A5_5A5A);
    send_value(32'hA5A6_5A59);
    send_value(32'hA5A7_5A5A);
    drain_results();

    write_reg(REG_FORMAT_MODE, 32'(MODE_DEC_GAP));
    write_reg(REG_START_VALUE, 32'hFFFF_FFFF);
    send_value(32'hFFFF_FFFF);
    send_value(32'h0000_FFFE);
    send_value(32'h0001_FFFF);
    send_value(32'h0000_FFFF);
    drain_results();

    write_reg(REG_FORMAT_MODE, 32'h7FFF_FFFF);
    write_reg(REG_START_VALUE, 32'h0);
    send_value(32'h0000_0000);
    send_value(32'h0000_00FF);
    send_value(32'h0000_FFFF);
    send_value(32'h0001_FFFE);
    send_value(32'h0002_FFFE);
    drain_results();

    for (int p = 0; p < 5; p++) random_phase(p, 30);

    drain_results();
    repeat (10) @(posedge clk);
    if (tracker.pending.size() != 0)
      tracker.report_mismatch($sformatf("%0d bytes never arrived", tracker.pending.size()));
    $display("covered %0d values (%0d rejected for gap), %0d bytes checked in all four formats",
             tracker.items, tracker.rejects, tracker.bytes_checked);
    $display("with random sender gaps and receiver stalls; %0d mismatches", tracker.mismatches);
    if (tracker.mismatches == 0) begin
      $display("PASS delta_decimal_stream_formatter");
    end else begin
      $display("FAIL delta_decimal_stream_formatter");
    end
    $finish;
  end

endmodule
